FILE: rtl/core/wtc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtc_pkg
// Shared widths, angle constants, arctangent table and state codes for the
// waypoint tracking controller.
// ----------------------------------------------------------------------------
package wtc_pkg;

    localparam int WP_DEPTH = 64;
    localparam int WP_AW    = $clog2(WP_DEPTH);
    localparam int WP_CW    = $clog2(WP_DEPTH + 1);

    localparam int CFG_AW   = 4;
    localparam int ZW       = 22;
    localparam int XW       = 38;
    localparam int MAW      = 36;
    localparam int MBW      = 18;
    localparam int PW       = MAW + MBW;
    localparam int CSW      = 18;
    localparam int DW       = 17;
    localparam int OW       = 24;
    localparam int NW       = 38;
    localparam int DENW     = 15;
    localparam int CORDIC_STEPS = 16;

    typedef logic [WP_AW-1:0]       t_addr;
    typedef logic [WP_AW:0]         t_wsum;
    typedef logic [WP_CW-1:0]       t_cnt;
    typedef logic signed [XW-1:0]   t_x;
    typedef logic signed [ZW-1:0]   t_z;
    typedef logic signed [MAW-1:0]  t_ma;
    typedef logic signed [MBW-1:0]  t_mb;
    typedef logic signed [PW-1:0]   t_prod;
    typedef logic signed [CSW-1:0]  t_cs;
    typedef logic signed [DW-1:0]   t_dlt;
    typedef logic signed [OW-1:0]   t_out;
    typedef logic [NW-1:0]          t_div;
    typedef logic [DENW-1:0]        t_den;

    localparam t_z    ANG_PI      = 22'sd205887;
    localparam t_z    ANG_2PI     = 22'sd411775;
    localparam t_z    ANG_HALF_PI = 22'sd102944;
    localparam t_x    CORDIC_ONE  = 38'sd39797;
    localparam t_out  OUT_MAX     = 24'sh7FFFFF;
    localparam t_out  OUT_MIN     = 24'sh800000;
    localparam t_prod Q28_ONE     = 54'sd268435456;
    localparam t_prod Q28_HALF    = 54'sd134217728;

    localparam logic [15:0] GAIN_RST = 16'd12288;
    localparam logic [14:0] POFF_RST = 15'd819;
    localparam logic [14:0] HOFF_RST = 15'd229;
    localparam logic [14:0] ARAD_RST = 15'd410;

    localparam logic MODE_APPEND = 1'b0;
    localparam logic MODE_POSE   = 1'b1;

    typedef enum logic [1:0] {
        REG_GAIN = 2'd0,
        REG_POFF = 2'd1,
        REG_HOFF = 2'd2,
        REG_ARAD = 2'd3
    } t_reg;

    typedef enum logic [4:0] {
        S_IDLE, S_DELTA, S_SQ_DX, S_SQ_DY, S_SQ_RR, S_ARRIVE,
        S_QXY, S_QWZ, S_QYY, S_QZZ, S_QB,
        S_VSTART, S_VWAIT, S_RSTART, S_RWAIT,
        S_PCX, S_PSY, S_PCY, S_PSX, S_PGS, S_PGT,
        S_TURN, S_DIV, S_OUT
    } t_state;

    function automatic logic [16:0] atan_entry(input logic [3:0] idx);
        logic [16:0] v;
        unique case (idx)
            4'd0:  v = 17'd51472;
            4'd1:  v = 17'd30386;
            4'd2:  v = 17'd16055;
            4'd3:  v = 17'd8150;
            4'd4:  v = 17'd4091;
            4'd5:  v = 17'd2047;
            4'd6:  v = 17'd1024;
            4'd7:  v = 17'd512;
            4'd8:  v = 17'd256;
            4'd9:  v = 17'd128;
            4'd10: v = 17'd64;
            4'd11: v = 17'd32;
            4'd12: v = 17'd16;
            4'd13: v = 17'd8;
            4'd14: v = 17'd4;
            4'd15: v = 17'd2;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/core/waypoint_tracking_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waypoint_tracking_controller
// Waypoint queue and feedback-linearized speed / turn command for a
// differential-drive robot.
//
// Input channel (i_in_valid / o_in_stall): one word per item. Mode append
// queues goal_x/goal_y; mode pose carries position and quaternion.
// Output channel (o_out_valid / i_out_stall): one result word per item,
// held in an output register until the receiver takes it.
// A pose word with a non-empty queue runs a 16-step CORDIC pass for yaw, a
// second 16-step pass for cos/sin, a shared 36x18 multiplier for the
// products and a 38-step restoring divider for the turn rate; popping a
// reached goal re-reads the waypoint memory.
// The block takes one item at a time; o_in_stall is high while an item is
// in work or its result cannot yet be loaded into the output register.
// Reset empties the queue and loads the default gain, offsets and arrival radius;
// waypoint memory content is not cleared. Configuration is through the APB-style port.
// ----------------------------------------------------------------------------
module waypoint_tracking_controller (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wtc_pkg::CFG_AW-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_mode,
    input  logic signed [15:0]            i_pos_x,
    input  logic signed [15:0]            i_pos_y,
    input  logic signed [15:0]            i_quat_w,
    input  logic signed [15:0]            i_quat_x,
    input  logic signed [15:0]            i_quat_y,
    input  logic signed [15:0]            i_quat_z,
    input  logic signed [15:0]            i_goal_x,
    input  logic signed [15:0]            i_goal_y,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [23:0]            o_linear_speed,
    output logic signed [23:0]            o_turn_rate,
    output logic [6:0]                    o_waypoints_left,
    output logic                          o_overflow
);

    wtc_pkg::t_state r_state, n_state;
    wtc_pkg::t_addr  r_head, n_head;
    wtc_pkg::t_cnt   r_count, n_count;

    logic [15:0]        r_gain;
    logic [14:0]        r_po;
    logic signed [14:0] r_ho;
    logic [14:0]        r_rr;

    logic [31:0]     r_mem [wtc_pkg::WP_DEPTH];
    logic [31:0]     r_rdata;

    logic signed [15:0] r_px, r_py, r_qw, r_qx, r_qy, r_qz;
    wtc_pkg::t_dlt   r_dx, r_dy;
    wtc_pkg::t_prod  r_acc, r_prod;
    wtc_pkg::t_x     r_a, r_b;
    wtc_pkg::t_z     r_th;
    wtc_pkg::t_cs    r_c, r_s;
    wtc_pkg::t_ma    r_sum1, r_sum2;
    wtc_pkg::t_out   r_speed, r_turn;
    logic            r_ovf;
    logic            r_pass;
    logic            r_tneg;

    logic            r_ovalid;
    wtc_pkg::t_out   r_o_speed, r_o_turn;
    wtc_pkg::t_cnt   r_o_count;
    logic            r_o_ovf;

    logic            in_acc;
    logic            out_free;
    logic            full;
    logic            rd_en, wr_en;
    wtc_pkg::t_addr  rd_addr, wr_addr, head_inc;
    wtc_pkg::t_wsum  wr_sum;
    wtc_pkg::t_ma    mul_a;
    wtc_pkg::t_mb    mul_b;
    logic            cv_start, cv_vec, cv_busy;
    wtc_pkg::t_x     cv_x, cv_y;
    wtc_pkg::t_z     cv_z;
    logic            dv_start, dv_busy;
    wtc_pkg::t_div   dv_num, dv_quot;
    wtc_pkg::t_prod  div_mag, div_sum;
    wtc_pkg::t_z     th0, th_wrap;
    wtc_pkg::t_prod  sp_full;
    wtc_pkg::t_prod  tq;

    function automatic wtc_pkg::t_z wrap_pi(input wtc_pkg::t_z v);
        wtc_pkg::t_z r;
        if (v > wtc_pkg::ANG_PI) begin
            r = v - wtc_pkg::ANG_2PI;
        end else if (v < -wtc_pkg::ANG_PI) begin
            r = v + wtc_pkg::ANG_2PI;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic wtc_pkg::t_out sat_out(input wtc_pkg::t_prod v);
        wtc_pkg::t_out r;
        if (v > wtc_pkg::t_prod'(wtc_pkg::OUT_MAX)) begin
            r = wtc_pkg::OUT_MAX;
        end else if (v < wtc_pkg::t_prod'(wtc_pkg::OUT_MIN)) begin
            r = wtc_pkg::OUT_MIN;
        end else begin
            r = wtc_pkg::t_out'(v);
        end
        return r;
    endfunction

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= wtc_pkg::GAIN_RST;
            r_po   <= wtc_pkg::POFF_RST;
            r_ho   <= $signed(wtc_pkg::HOFF_RST);
            r_rr   <= wtc_pkg::ARAD_RST;
        end else if (psel && penable && pwrite) begin
            unique case (wtc_pkg::t_reg'(paddr[3:2]))
                wtc_pkg::REG_GAIN: r_gain <= pwdata[15:0];
                wtc_pkg::REG_POFF: r_po   <= pwdata[14:0];
                wtc_pkg::REG_HOFF: r_ho   <= $signed(pwdata[14:0]);
                wtc_pkg::REG_ARAD: r_rr   <= pwdata[14:0];
            endcase
        end
    end

    always_comb begin
        unique case (wtc_pkg::t_reg'(paddr[3:2]))
            wtc_pkg::REG_GAIN: prdata = {16'd0, r_gain};
            wtc_pkg::REG_POFF: prdata = {17'd0, r_po};
            wtc_pkg::REG_HOFF: prdata = {{17{r_ho[14]}}, r_ho};
            wtc_pkg::REG_ARAD: prdata = {17'd0, r_rr};
        endcase
    end

    // handshake and address arithmetic
    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != wtc_pkg::S_IDLE);
    assign out_free   = !r_ovalid || !i_out_stall;
    assign full       = (r_count == wtc_pkg::t_cnt'(wtc_pkg::WP_DEPTH));
    assign head_inc   = (r_head == wtc_pkg::t_addr'(wtc_pkg::WP_DEPTH - 1)) ?
                        '0 : r_head + 1'b1;
    assign wr_sum     = {1'b0, r_head} + wtc_pkg::t_wsum'(r_count);
    assign wr_addr    = (wr_sum >= wtc_pkg::t_wsum'(wtc_pkg::WP_DEPTH)) ?
                        wtc_pkg::t_addr'(wr_sum - wtc_pkg::t_wsum'(wtc_pkg::WP_DEPTH)) :
                        wtc_pkg::t_addr'(wr_sum);

    always_comb begin
        th0     = cv_z - (wtc_pkg::t_z'(r_ho) <<< 4);
        th_wrap = wrap_pi(wrap_pi(th0));
        sp_full = (r_prod + wtc_pkg::Q28_HALF) >>> 28;
        div_mag = r_prod[wtc_pkg::PW-1] ? -r_prod : r_prod;
        div_sum = div_mag + (wtc_pkg::t_prod'(r_po) <<< 15);
        dv_num  = wtc_pkg::t_div'(div_sum >>> 16);
        tq      = r_tneg ? -$signed(wtc_pkg::t_prod'(dv_quot)) :
                           $signed(wtc_pkg::t_prod'(dv_quot));
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wtc_pkg::S_IDLE;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_count  = r_count;
        rd_en    = 1'b0;
        rd_addr  = r_head;
        wr_en    = 1'b0;
        cv_start = 1'b0;
        cv_vec   = 1'b1;
        dv_start = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        unique case (r_state)
            wtc_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (i_mode == wtc_pkg::MODE_APPEND) begin
                        if (!full) begin
                            wr_en   = 1'b1;
                            n_count = r_count + 1'b1;
                        end
                        n_state = wtc_pkg::S_OUT;
                    end else if (r_count == '0) begin
                        n_state = wtc_pkg::S_OUT;
                    end else begin
                        rd_en   = 1'b1;
                        n_state = wtc_pkg::S_DELTA;
                    end
                end
            end
            wtc_pkg::S_DELTA: begin
                n_state = r_pass ? wtc_pkg::S_QXY : wtc_pkg::S_SQ_DX;
            end
            wtc_pkg::S_SQ_DX: begin
                mul_a   = wtc_pkg::t_ma'(r_dx);
                mul_b   = wtc_pkg::t_mb'(r_dx);
                n_state = wtc_pkg::S_SQ_DY;
            end
            wtc_pkg::S_SQ_DY: begin
                mul_a   = wtc_pkg::t_ma'(r_dy);
                mul_b   = wtc_pkg::t_mb'(r_dy);
                n_state = wtc_pkg::S_SQ_RR;
            end
            wtc_pkg::S_SQ_RR: begin
                mul_a   = wtc_pkg::t_ma'({1'b0, r_rr});
                mul_b   = wtc_pkg::t_mb'({1'b0, r_rr});
                n_state = wtc_pkg::S_ARRIVE;
            end
            wtc_pkg::S_ARRIVE: begin
                if (r_acc < r_prod) begin
                    n_head  = head_inc;
                    n_count = r_count - 1'b1;
                    if (r_count == wtc_pkg::t_cnt'(1)) begin
                        n_state = wtc_pkg::S_OUT;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = head_inc;
                        n_state = wtc_pkg::S_DELTA;
                    end
                end else begin
                    n_state = wtc_pkg::S_QXY;
                end
            end
            wtc_pkg::S_QXY: begin
                mul_a   = wtc_pkg::t_ma'(r_qx);
                mul_b   = wtc_pkg::t_mb'(r_qy);
                n_state = wtc_pkg::S_QWZ;
            end
            wtc_pkg::S_QWZ: begin
                mul_a   = wtc_pkg::t_ma'(r_qw);
                mul_b   = wtc_pkg::t_mb'(r_qz);
                n_state = wtc_pkg::S_QYY;
            end
            wtc_pkg::S_QYY: begin
                mul_a   = wtc_pkg::t_ma'(r_qy);
                mul_b   = wtc_pkg::t_mb'(r_qy);
                n_state = wtc_pkg::S_QZZ;
            end
            wtc_pkg::S_QZZ: begin
                mul_a   = wtc_pkg::t_ma'(r_qz);
                mul_b   = wtc_pkg::t_mb'(r_qz);
                n_state = wtc_pkg::S_QB;
            end
            wtc_pkg::S_QB: begin
                n_state = wtc_pkg::S_VSTART;
            end
            wtc_pkg::S_VSTART: begin
                cv_start = 1'b1;
                n_state  = wtc_pkg::S_VWAIT;
            end
            wtc_pkg::S_VWAIT: begin
                if (!cv_busy) begin
                    n_state = wtc_pkg::S_RSTART;
                end
            end
            wtc_pkg::S_RSTART: begin
                cv_start = 1'b1;
                cv_vec   = 1'b0;
                n_state  = wtc_pkg::S_RWAIT;
            end
            wtc_pkg::S_RWAIT: begin
                cv_vec = 1'b0;
                if (!cv_busy) begin
                    n_state = wtc_pkg::S_PCX;
                end
            end
            wtc_pkg::S_PCX: begin
                mul_a   = wtc_pkg::t_ma'(r_c);
                mul_b   = wtc_pkg::t_mb'(r_dx);
                n_state = wtc_pkg::S_PSY;
            end
            wtc_pkg::S_PSY: begin
                mul_a   = wtc_pkg::t_ma'(r_s);
                mul_b   = wtc_pkg::t_mb'(r_dy);
                n_state = wtc_pkg::S_PCY;
            end
            wtc_pkg::S_PCY: begin
                mul_a   = wtc_pkg::t_ma'(r_c);
                mul_b   = wtc_pkg::t_mb'(r_dy);
                n_state = wtc_pkg::S_PSX;
            end
            wtc_pkg::S_PSX: begin
                mul_a   = wtc_pkg::t_ma'(r_s);
                mul_b   = wtc_pkg::t_mb'(r_dx);
                n_state = wtc_pkg::S_PGS;
            end
            wtc_pkg::S_PGS: begin
                mul_a   = r_sum1;
                mul_b   = wtc_pkg::t_mb'({1'b0, r_gain});
                n_state = wtc_pkg::S_PGT;
            end
            wtc_pkg::S_PGT: begin
                mul_a   = r_sum2;
                mul_b   = wtc_pkg::t_mb'({1'b0, r_gain});
                n_state = wtc_pkg::S_TURN;
            end
            wtc_pkg::S_TURN: begin
                if (r_po == '0) begin
                    n_state = wtc_pkg::S_OUT;
                end else begin
                    dv_start = 1'b1;
                    n_state  = wtc_pkg::S_DIV;
                end
            end
            wtc_pkg::S_DIV: begin
                if (!dv_busy) begin
                    n_state = wtc_pkg::S_OUT;
                end
            end
            wtc_pkg::S_OUT: begin
                if (out_free) begin
                    n_state = wtc_pkg::S_IDLE;
                end
            end
            default: n_state = wtc_pkg::S_IDLE;
        endcase
    end

    // waypoint memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= {i_goal_y, i_goal_x};
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass <= 1'b0;
        end else if (r_state == wtc_pkg::S_IDLE) begin
            r_pass <= 1'b0;
        end else if (r_state == wtc_pkg::S_ARRIVE) begin
            r_pass <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            wtc_pkg::S_IDLE: begin
                if (in_acc) begin
                    r_px    <= i_pos_x;
                    r_py    <= i_pos_y;
                    r_qw    <= i_quat_w;
                    r_qx    <= i_quat_x;
                    r_qy    <= i_quat_y;
                    r_qz    <= i_quat_z;
                    r_speed <= '0;
                    r_turn  <= '0;
                    r_ovf   <= (i_mode == wtc_pkg::MODE_APPEND) && full;
                end
            end
            wtc_pkg::S_DELTA: begin
                r_dx <= wtc_pkg::t_dlt'($signed(r_rdata[15:0])) - wtc_pkg::t_dlt'(r_px);
                r_dy <= wtc_pkg::t_dlt'($signed(r_rdata[31:16])) - wtc_pkg::t_dlt'(r_py);
            end
            wtc_pkg::S_SQ_DY: r_acc <= r_prod;
            wtc_pkg::S_SQ_RR: r_acc <= r_acc + r_prod;
            wtc_pkg::S_QWZ:   r_acc <= r_prod;
            wtc_pkg::S_QYY:   r_a   <= wtc_pkg::t_x'((r_acc + r_prod) <<< 1);
            wtc_pkg::S_QZZ:   r_acc <= r_prod;
            wtc_pkg::S_QB: begin
                r_b <= wtc_pkg::t_x'(wtc_pkg::Q28_ONE - ((r_acc + r_prod) <<< 1));
            end
            wtc_pkg::S_VWAIT: begin
                if (!cv_busy) begin
                    r_th <= th_wrap;
                end
            end
            wtc_pkg::S_RWAIT: begin
                if (!cv_busy) begin
                    r_c <= wtc_pkg::t_cs'(cv_x);
                    r_s <= wtc_pkg::t_cs'(cv_y);
                end
            end
            wtc_pkg::S_PSY:   r_acc  <= r_prod;
            wtc_pkg::S_PCY:   r_sum1 <= wtc_pkg::t_ma'(r_acc + r_prod);
            wtc_pkg::S_PSX:   r_acc  <= r_prod;
            wtc_pkg::S_PGS:   r_sum2 <= wtc_pkg::t_ma'(r_acc - r_prod);
            wtc_pkg::S_PGT:   r_speed <= sat_out(sp_full);
            wtc_pkg::S_TURN: begin
                r_tneg <= r_prod[wtc_pkg::PW-1];
                if (r_po == '0) begin
                    if (r_prod == '0) begin
                        r_turn <= '0;
                    end else begin
                        r_turn <= r_prod[wtc_pkg::PW-1] ? wtc_pkg::OUT_MIN : wtc_pkg::OUT_MAX;
                    end
                end
            end
            wtc_pkg::S_DIV: begin
                if (!dv_busy) begin
                    r_turn <= sat_out(tq);
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if ((r_state == wtc_pkg::S_OUT) && out_free) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == wtc_pkg::S_OUT) && out_free) begin
            r_o_speed <= r_speed;
            r_o_turn  <= r_turn;
            r_o_count <= r_count;
            r_o_ovf   <= r_ovf;
        end
    end

    assign o_out_valid      = r_ovalid;
    assign o_linear_speed   = r_o_speed;
    assign o_turn_rate      = r_o_turn;
    assign o_waypoints_left = 7'(r_o_count);
    assign o_overflow       = r_o_ovf;

    wtc_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cv_start),
        .i_vec   (cv_vec),
        .i_x     (r_b),
        .i_y     (r_a),
        .i_z     (r_th),
        .o_busy  (cv_busy),
        .o_x     (cv_x),
        .o_y     (cv_y),
        .o_z     (cv_z)
    );

    wtc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dv_start),
        .i_num   (dv_num),
        .i_den   (r_po),
        .o_busy  (dv_busy),
        .o_quot  (dv_quot)
    );

endmodule

FILE: rtl/core/wtc_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtc_cordic
// Shared CORDIC unit, one micro-rotation per cycle: vectoring mode gives the
// angle of (x, y), rotation mode gives cos and sin of z.
// ----------------------------------------------------------------------------
module wtc_cordic (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_vec,
    input  wtc_pkg::t_x   i_x,
    input  wtc_pkg::t_x   i_y,
    input  wtc_pkg::t_z   i_z,
    output logic          o_busy,
    output wtc_pkg::t_x   o_x,
    output wtc_pkg::t_x   o_y,
    output wtc_pkg::t_z   o_z
);

    logic          r_busy;
    logic [3:0]    r_i;
    logic          r_vec;
    logic          r_neg;
    logic          r_zero;
    wtc_pkg::t_x   r_x;
    wtc_pkg::t_x   r_y;
    wtc_pkg::t_z   r_z;

    wtc_pkg::t_x   xs;
    wtc_pkg::t_x   ys;
    wtc_pkg::t_z   at;
    logic          up;

    always_comb begin
        xs = r_x >>> r_i;
        ys = r_y >>> r_i;
        at = $signed({{(wtc_pkg::ZW - 17){1'b0}}, wtc_pkg::atan_entry(r_i)});
        up = r_vec ? (r_y > 0) : (r_z < 0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_i    <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_i    <= '0;
        end else if (r_busy) begin
            r_i <= r_i + 4'd1;
            if (r_i == 4'(wtc_pkg::CORDIC_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_vec <= i_vec;
            if (i_vec) begin
                r_neg  <= 1'b0;
                r_zero <= (i_x == 0) && (i_y == 0);
                if (i_x < 0) begin
                    r_x <= -i_x;
                    r_y <= -i_y;
                    r_z <= (i_y >= 0) ? wtc_pkg::ANG_PI : -wtc_pkg::ANG_PI;
                end else begin
                    r_x <= i_x;
                    r_y <= i_y;
                    r_z <= '0;
                end
            end else begin
                r_zero <= 1'b0;
                r_x    <= wtc_pkg::CORDIC_ONE;
                r_y    <= '0;
                if (i_z > wtc_pkg::ANG_HALF_PI) begin
                    r_z   <= i_z - wtc_pkg::ANG_PI;
                    r_neg <= 1'b1;
                end else if (i_z < -wtc_pkg::ANG_HALF_PI) begin
                    r_z   <= i_z + wtc_pkg::ANG_PI;
                    r_neg <= 1'b1;
                end else begin
                    r_z   <= i_z;
                    r_neg <= 1'b0;
                end
            end
        end else if (r_busy) begin
            if (up) begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + at;
            end else begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - at;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_x    = r_neg ? -r_x : r_x;
    assign o_y    = r_neg ? -r_y : r_y;
    assign o_z    = r_zero ? '0 : r_z;

endmodule

FILE: rtl/core/wtc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wtc_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  wtc_pkg::t_div i_num,
    input  wtc_pkg::t_den i_den,
    output logic          o_busy,
    output wtc_pkg::t_div o_quot
);

    logic                           r_busy;
    logic [$clog2(wtc_pkg::NW)-1:0] r_cnt;
    wtc_pkg::t_div                  r_num;
    wtc_pkg::t_den                  r_den;
    wtc_pkg::t_den                  r_rem;

    logic [wtc_pkg::DENW:0]         trial;
    logic [wtc_pkg::DENW:0]         diff;
    logic                           fits;

    always_comb begin
        trial = {r_rem, r_num[wtc_pkg::NW-1]};
        diff  = trial - {1'b0, r_den};
        fits  = trial >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == ($clog2(wtc_pkg::NW))'(wtc_pkg::NW - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[wtc_pkg::NW-2:0], fits};
            r_rem <= fits ? diff[wtc_pkg::DENW-1:0] : trial[wtc_pkg::DENW-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_num;

endmodule
